// ===== src/binary_min_heap_queue_top_macros.svh =====
// Assertion shorthands for the heap queue checker
`ifndef BINARY_MIN_HEAP_QUEUE_TOP_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_TOP_MACROS_SVH

// same-cycle implication
`define BMHQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("heap queue check failed");

// next-cycle implication
`define BMHQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("heap queue check failed");

`endif

// ===== src/bmhq_pkg.sv =====
package bmhq_pkg;

   typedef enum logic [0:0] {
      KIND_PUSH = 1'b0,
      KIND_POP  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_READ,
      ST_UP_CMP,
      ST_POP_ROOT,
      ST_POP_LAST,
      ST_DN_LEFT,
      ST_DN_RIGHT,
      ST_DN_CMP,
      ST_DONE
   } state_type;

endpackage

// ===== src/bmhq_req_if.sv =====
interface bmhq_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [31:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

// ===== src/bmhq_rsp_if.sv =====
interface bmhq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] popped_value;
   logic [1:0]         status;
   logic [4:0]         count;

   modport source (output valid, output popped_value, output status, output count,
                   input ready);
   modport sink   (input valid, input popped_value, input status, input count,
                   output ready);
endinterface

// ===== src/binary_min_heap_queue_top.sv =====
// Operation: a push climbs from the new last slot, reading the parent and comparing, while
//   strictly smaller; a pop reads the root, moves the last entry there and descends, reading
//   left then right child and comparing; at most log2(CAPACITY) levels. A push to a full heap
//   or a pop from an empty one goes straight to the result. A stalled result holds it back.
// Throughput: one operation at a time, next transfer in as the result is offered; the RAM
//   (one read, one write per cycle) sets the pace. Reset: sync, count/control; RAM kept.
module binary_min_heap_queue_top
   import bmhq_pkg::*;
#(
   parameter int CAPACITY  = 16,
   parameter int KEY_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   bmhq_req_if.sink   req_chan,
   bmhq_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(CAPACITY);       // RAM address width
   localparam int CW = $clog2(CAPACITY + 1);   // count width, holds CAPACITY
   localparam int XW = AW + 2;                 // child index width, no overflow

   // ---------------------------------------------------------------------
   // Heap RAM: one write and one registered read per cycle.
   // The sifting key is carried in key_ff and the hole is filled by moving
   // the neighbour across, so a level costs one write and one read per key
   // compared.
   // ---------------------------------------------------------------------
   logic signed [KEY_WIDTH-1:0] heap_mem [CAPACITY];
   logic signed [KEY_WIDTH-1:0] rd_data_ff;
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic signed [KEY_WIDTH-1:0] wr_data;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= heap_mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Control and datapath registers
   // ---------------------------------------------------------------------
   state_type                   state_ff, state_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [AW-1:0]               pos_ff, pos_in;
   logic signed [KEY_WIDTH-1:0] key_ff, key_in;       // key being sifted
   logic signed [KEY_WIDTH-1:0] root_ff, root_in;     // popped key, zero otherwise
   logic signed [KEY_WIDTH-1:0] left_ff, left_in;     // left child during sift-down
   logic                        right_ok_ff, right_ok_in;
   status_type                  status_ff, status_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]          rsp_value_ff, rsp_value_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;
   logic [4:0]                  rsp_count_ff, rsp_count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      root_ff       <= root_in;
      left_ff       <= left_in;
      right_ok_ff   <= right_ok_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // ---------------------------------------------------------------------
   // Shared conditions
   // ---------------------------------------------------------------------
   logic                        req_fire;
   logic                        heap_full, heap_empty;
   logic [KEY_WIDTH+31:0]       value_ext;
   logic signed [KEY_WIDTH-1:0] key_new;
   logic [AW-1:0]               parent_idx;
   logic                        up_less;
   logic [CW-1:0]               count_dec;
   logic [XW-1:0]               left_idx, right_idx, count_ext;
   logic                        dn_no_left;
   logic                        pick_right;
   logic signed [KEY_WIDTH-1:0] pick_val;
   logic [AW-1:0]               pick_idx;
   logic                        dn_less;
   logic                        rsp_free;
   logic [KEY_WIDTH+31:0]       root_ext;
   logic [CW+4:0]               count_wide;

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign heap_full  = (count_ff == CW'(CAPACITY));
   assign heap_empty = (count_ff == '0);

   // key is the 32-bit field fitted to KEY_WIDTH: sign-extended or truncated
   assign value_ext = {{KEY_WIDTH{req_chan.value[31]}}, req_chan.value};
   assign key_new   = value_ext[KEY_WIDTH-1:0];

   // sift-up: parent of the hole, move on only while strictly smaller
   assign parent_idx = AW'((pos_ff - AW'(1)) >> 1);
   assign up_less    = (key_ff < rd_data_ff);

   assign count_dec = count_ff - CW'(1);

   // sift-down: children of the hole, only slots below the count count
   assign count_ext  = XW'(count_ff);
   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = left_idx + XW'(1);
   assign dn_no_left = (left_idx >= count_ext);
   // right wins only when strictly smaller; ties keep the left child
   assign pick_right = right_ok_ff && (rd_data_ff < left_ff);
   assign pick_val   = pick_right ? rd_data_ff : left_ff;
   assign pick_idx   = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
   assign dn_less    = (pick_val < key_ff);

   // output register may be loaded when empty or being drained this cycle
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;

   assign root_ext   = {{32{root_ff[KEY_WIDTH-1]}}, root_ff};
   assign count_wide = {5'b0, count_ff};

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.kind == KIND_PUSH) begin
                  state_in = heap_full ? ST_DONE : ST_UP_READ;
               end else begin
                  state_in = heap_empty ? ST_DONE : ST_POP_ROOT;
               end
            end
         end
         ST_UP_READ: begin
            state_in = (pos_ff == '0) ? ST_DONE : ST_UP_CMP;
         end
         ST_UP_CMP: begin
            state_in = up_less ? ST_UP_READ : ST_DONE;
         end
         ST_POP_ROOT: begin
            state_in = (count_dec == '0) ? ST_DONE : ST_POP_LAST;
         end
         ST_POP_LAST: begin
            state_in = ST_DN_LEFT;
         end
         ST_DN_LEFT: begin
            state_in = dn_no_left ? ST_DONE : ST_DN_RIGHT;
         end
         ST_DN_RIGHT: begin
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            state_in = dn_less ? ST_DN_LEFT : ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath and RAM control
   // ---------------------------------------------------------------------
   always_comb begin
      count_in      = count_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      root_in       = root_ff;
      left_in       = left_ff;
      right_ok_in   = right_ok_ff;
      status_in     = status_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = key_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               root_in   = '0;
               status_in = STATUS_OK;
               if (req_chan.kind == KIND_PUSH) begin
                  if (heap_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     key_in   = key_new;
                     pos_in   = count_ff[AW-1:0];
                     count_in = count_ff + CW'(1);
                  end
               end else begin
                  if (heap_empty) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = '0;
                  end
               end
            end
         end
         ST_UP_READ: begin
            if (pos_ff == '0) begin
               wr_en = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = parent_idx;
            end
         end
         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (up_less) begin
               wr_data = rd_data_ff;   // parent drops into the hole
               pos_in  = parent_idx;
            end
         end
         ST_POP_ROOT: begin
            root_in  = rd_data_ff;
            count_in = count_dec;
            if (count_dec != '0) begin
               rd_en   = 1'b1;
               rd_addr = count_dec[AW-1:0];   // last entry moves to the root
            end
         end
         ST_POP_LAST: begin
            key_in = rd_data_ff;
            pos_in = '0;
         end
         ST_DN_LEFT: begin
            if (dn_no_left) begin
               wr_en = 1'b1;
            end else begin
               rd_en   = 1'b1;
               rd_addr = left_idx[AW-1:0];
            end
         end
         ST_DN_RIGHT: begin
            left_in     = rd_data_ff;
            right_ok_in = (right_idx < count_ext);
            if (right_idx < count_ext) begin
               rd_en   = 1'b1;
               rd_addr = right_idx[AW-1:0];
            end
         end
         ST_DN_CMP: begin
            wr_en = 1'b1;
            if (dn_less) begin
               wr_data = pick_val;     // smaller child rises into the hole
               pos_in  = pick_idx;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = root_ext[31:0];
               rsp_status_in = status_ff;
               rsp_count_in  = count_wide[4:0];
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Ports
   // ---------------------------------------------------------------------
   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.popped_value = rsp_value_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.count        = rsp_count_ff;

endmodule

// ===== src/bmhq_checker.sv =====
`include "binary_min_heap_queue_top_macros.svh"

module bmhq_checker
   import bmhq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] popped_value,
   input logic [1:0]  status,
   input logic [4:0]  count
);

   // one operation in flight: busy right after a transfer in
   `BMHQ_ASSERT_NEXT(busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // empty pop reports nothing removed and an empty heap
   `BMHQ_ASSERT_IMPLY(empty_pop_shape, clock, reset, rsp_valid && status == STATUS_EMPTY, count == 5'd0 && popped_value == 32'd0)

   // a dropped push removes nothing
   `BMHQ_ASSERT_IMPLY(full_push_zero, clock, reset, rsp_valid && status == STATUS_FULL, popped_value == 32'd0)

   // stalled result holds
   `BMHQ_ASSERT_NEXT(rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(popped_value) && $stable(status) && $stable(count))

endmodule

bind binary_min_heap_queue_top bmhq_checker u_bmhq_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .popped_value (rsp_chan.popped_value),
   .status       (rsp_chan.status),
   .count        (rsp_chan.count)
);

// ===== tb/bmhq_order_check.sv =====
module bmhq_order_check
   import bmhq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic clock,
   input  logic reset,
   bmhq_req_if  req_mon,
   bmhq_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [31:0] popped_value;
      status_type         status;
      logic [4:0]         count;
   } heap_result_t;

   // shadow heap, keys held signed so plain compares give key order
   logic signed [31:0] shadow_keys [CAPACITY];
   int                 shadow_count;
   heap_result_t       awaited_results [$];

   function automatic heap_result_t apply_heap_op(input kind_type op,
                                                  input logic signed [31:0] key);
      heap_result_t       res;
      int                 pos;
      int                 parent;
      int                 left;
      int                 pick;
      logic signed [31:0] held;
      res.popped_value = '0;
      res.status       = STATUS_OK;
      if (op == KIND_PUSH) begin
         if (shadow_count >= CAPACITY) begin
            res.status = STATUS_FULL;
         end else begin
            pos = shadow_count;
            shadow_keys[pos] = key;
            shadow_count++;
            // climb while strictly below the parent
            while (pos > 0) begin
               parent = (pos - 1) / 2;
               if (shadow_keys[pos] >= shadow_keys[parent]) break;
               held                = shadow_keys[pos];
               shadow_keys[pos]    = shadow_keys[parent];
               shadow_keys[parent] = held;
               pos                 = parent;
            end
         end
      end else if (shadow_count == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         res.popped_value = shadow_keys[0];
         shadow_count--;
         shadow_keys[0] = shadow_keys[shadow_count];
         pos = 0;
         // descend towards the smaller child, left wins a tie
         while (1'b1) begin
            left = 2 * pos + 1;
            if (left >= shadow_count) break;
            pick = left;
            if (left + 1 < shadow_count && shadow_keys[left + 1] < shadow_keys[left])
               pick = left + 1;
            if (shadow_keys[pick] >= shadow_keys[pos]) break;
            held              = shadow_keys[pos];
            shadow_keys[pos]  = shadow_keys[pick];
            shadow_keys[pick] = held;
            pos               = pick;
         end
      end
      res.count = 5'(shadow_count);
      return res;
   endfunction

   task automatic note_mismatch(input string field, input longint want, input longint got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%t heap mismatch on %s: expected %0d, actual %0d", $realtime, field,
                  want, got);
   endtask

   always @(posedge clock) begin
      heap_result_t want;
      if (reset) begin
         shadow_count   = 0;
         mismatch_count = 0;
         awaited_results.delete();
      end else begin
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            awaited_results.push_back(apply_heap_op(kind_type'(req_mon.kind), req_mon.value));
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%t heap result with nothing outstanding: value %0d status %0d count %0d",
                           $realtime, rsp_mon.popped_value, rsp_mon.status, rsp_mon.count);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_mon.popped_value !== want.popped_value)
                  note_mismatch("popped_value", longint'(want.popped_value),
                                longint'($signed(rsp_mon.popped_value)));
               if (rsp_mon.status !== want.status)
                  note_mismatch("status", longint'(want.status), longint'(rsp_mon.status));
               if (rsp_mon.count !== want.count)
                  note_mismatch("count", longint'(want.count), longint'(rsp_mon.count));
            end
         end
      end
      results_pending = awaited_results.size();
   end

endmodule

// ===== tb/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bmhq_pkg::*;

   localparam int CAPACITY    = 16;
   localparam int HOLD_CYCLES = 300;  // receiver hold-off, long enough to back up the input
   localparam int DRAIN_WAIT  = 40;   // well past the slowest pop

   logic clock;
   logic reset;
   int   mismatch_count;
   int   results_pending;

   // idling switch shared by both sides; cleared for one calm phase
   bit   idle_enabled = 1'b1;
   // hold-off requests to the receiver; it counts the stall cycles itself
   int   holds_asked  = 0;

   bmhq_req_if req_chan ();
   bmhq_rsp_if rsp_chan ();

   binary_min_heap_queue_top #(
      .CAPACITY (CAPACITY),
      .KEY_WIDTH(32)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // watches both channels, predicts each result and compares
   bmhq_order_check #(
      .CAPACITY(CAPACITY)
   ) order_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .results_pending(results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop: many times the slowest legal run with both hold-offs.
   initial begin
      #1000000;
      $display("Simulation FAILED");
      $finish;
   end

   // Result side: ready changes on the falling edge only. A pending hold-off
   // request wins over random idling; during it ready stays low throughout.
   initial begin
      int hold_left;
      int holds_served;
      hold_left    = 0;
      holds_served = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            rsp_chan.ready <= 1'b0;
         end else if (idle_enabled && $urandom_range(99) < 15) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Offer one operation and return at the falling edge after its transfer.
   // valid stays high into the next offer unless a gap is drawn, so it only
   // gets one assignment per falling edge.
   task automatic offer_op(input kind_type op, input logic signed [31:0] key);
      int gap;
      gap = 0;
      if (idle_enabled && $urandom_range(99) < 15) gap = $urandom_range(3, 1);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.kind  <= op;
      req_chan.value <= key;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   // Sender pause: drop valid and wait until every result is back.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      wait (results_pending == 0);
      @(negedge clock);
   endtask

   // Keys: full range, a narrow band around zero for ties, and the extremes.
   function automatic logic signed [31:0] draw_key();
      case ($urandom_range(9))
         0, 1, 2, 3: draw_key = $urandom;
         4, 5, 6:    draw_key = $signed($urandom_range(8)) - 4;
         7:          draw_key = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         8:          draw_key = 32'sh80000000 + $urandom_range(3);
         default:    draw_key = 32'sh7fffffff - $urandom_range(3);
      endcase
   endfunction

   initial begin
      // push share per random phase: balanced, filling, draining, and near the ends
      int unsigned push_share [8];
      logic signed [31:0] fill_keys [16];
      int phase;
      int n;

      push_share = '{50, 80, 20, 65, 35, 90, 10, 50};
      fill_keys  = '{
         32'sh7fffffff, 32'sh80000000, 0, -1, 1, 5, 5, -5,
         3, 3, 100, -100, 32'sh7ffffffe, 32'sh80000001, 7, 0};

      req_chan.valid <= 1'b0;
      req_chan.kind  <= KIND_PUSH;
      req_chan.value <= '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: pop on an empty heap, fill to capacity with the key extremes
      // and repeated keys, one push to a full heap, then pops across the ties.
      offer_op(KIND_POP, $urandom);
      foreach (fill_keys[i]) offer_op(KIND_PUSH, fill_keys[i]);
      offer_op(KIND_PUSH, 42);
      repeat (7) offer_op(KIND_POP, $urandom);
      drain_results();

      // Random phases, about 115 transfers each.
      for (phase = 0; phase < 8; phase++) begin
         // phases 1 and 5 fill the heap while the receiver holds off; phase 3 never idles
         if (phase == 1 || phase == 5) holds_asked++;
         idle_enabled = (phase != 3);
         for (n = 0; n < 115; n++) begin
            if ($urandom_range(99) < push_share[phase])
               offer_op(KIND_PUSH, draw_key());
            else
               offer_op(KIND_POP, $urandom);
         end
         if (phase % 2 == 1) drain_results();
      end
      idle_enabled = 1'b1;

      // All stimulus transferred: let the last results come back, then a margin
      // so a stray extra result would still be caught.
      req_chan.valid <= 1'b0;
      wait (results_pending == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
